### design/i2cm_pkg.sv
package i2cm_pkg;

	localparam int unsigned BYTE_BITS       = 8;
	localparam int unsigned CFG_W           = 8;
	localparam int unsigned CFG_IDX_W       = 1;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned S_TDATA_W       = 24;
	localparam int unsigned S_TUSER_W       = 4;
	localparam int unsigned M_TDATA_W       = 16;

	localparam logic [CFG_W-1:0] STRETCH_RST = 8'd255;
	localparam logic [CFG_W-1:0] SETUP_RST   = 8'd2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SETUP   = 1'b1;

	// func codes on the input beat
	localparam logic [2:0] FN_START    = 3'd0;
	localparam logic [2:0] FN_WRITE    = 3'd1;
	localparam logic [2:0] FN_RD_ACK   = 3'd2;
	localparam logic [2:0] FN_RD_NACK  = 3'd3;
	localparam logic [2:0] FN_STOP     = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NACK    = 2'd1;
	localparam logic [1:0] ST_ARB     = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	typedef enum logic [2:0] {
		CK_NONE    = 3'd0,
		CK_START   = 3'd1,
		CK_WRITE   = 3'd2,
		CK_RD_ACK  = 3'd3,
		CK_RD_NACK = 3'd4,
		CK_STOP    = 3'd5
	} cmd_kind_t;

	// one classified tick as it sits in the queue
	typedef struct packed {
		cmd_kind_t                kind;
		logic [BYTE_BITS-1:0]     byte_val;
		logic                     scl;
		logic                     sda;
	} tick_t;

	typedef struct packed {
		logic [CFG_W-1:0] stretch_timeout;
		logic [CFG_W-1:0] stop_setup_ticks;
	} cfg_t;

	typedef enum logic [17:0] {
		PH_IDLE       = 18'h00001,
		PH_START      = 18'h00002,
		PH_TX_LOW     = 18'h00004,
		PH_TX_RISE    = 18'h00008,
		PH_TX_WAIT    = 18'h00010,
		PH_ACK_LOW    = 18'h00020,
		PH_ACK_RISE   = 18'h00040,
		PH_ACK_WAIT   = 18'h00080,
		PH_RX_LOW     = 18'h00100,
		PH_RX_RISE    = 18'h00200,
		PH_RX_WAIT    = 18'h00400,
		PH_ANS_LOW    = 18'h00800,
		PH_ANS_RISE   = 18'h01000,
		PH_ANS_WAIT   = 18'h02000,
		PH_STOP_LOW   = 18'h04000,
		PH_STOP_RISE  = 18'h08000,
		PH_STOP_WAIT  = 18'h10000,
		PH_STOP_SETUP = 18'h20000
	} phase_t;

endpackage

### design/i2c_master_byte_engine.sv
// Pin-level I2C master driven one tick per input beat.
//
// Slave channel (s_*): each beat is one sampling tick. It carries the sampled
// SCL/SDA levels and, when cmd_valid is set, a command (start with address and
// direction, write byte, read with ACK, read with NACK, stop). Commands that
// arrive while a command runs, and unknown func codes, are dropped.
// Master channel (m_*): exactly one result beat per input beat, in order, with
// the SCL/SDA drive levels, busy, done, status and the last received byte.
// Configuration: write stretch_timeout (index 0) or stop_setup_ticks (index 1)
// through cfg_we/cfg_addr/cfg_wdata, only while no tick is in flight.
//
// Throughput: one tick per clock cycle while m_tready stays high. A beat accepted
// is classified into a small tick queue; the bit engine pops it from there and
// writes its result into the output register, which drives m_tdata.
// When m_tready drops, the engine holds its result and stops popping, the queue
// fills, then s_tready falls; nothing is lost.
// Reset: both lines released, engine idle, registers at 255 and 2, queue empty.
module i2c_master_byte_engine
	import i2cm_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// dev_addr[6:0], read_not_write[7], wr_data[15:8], scl_in[16], sda_in[17], zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd_valid[0], func[3:1]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// scl_out[0], sda_out[1], busy_res[2], done_res[3], status[5:4], rd_data[13:6], zero
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	tick_t push_data;
	logic  tick_valid;
	logic  tick_ready;
	tick_t tick;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stretch_timeout  <= STRETCH_RST;
			cfg_q.stop_setup_ticks <= SETUP_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_STRETCH: cfg_q.stretch_timeout  <= cfg_wdata;
				REG_SETUP:   cfg_q.stop_setup_ticks <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// front: unpack and classify each beat
	i2cm_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// queue: decouple the front from engine stalls
	i2cm_tick_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (tick_valid),
		.pop_ready  (tick_ready),
		.pop_data   (tick)
	);

	// back: bit-level sequencer plus output register
	i2cm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

### design/i2cm_front.sv
module i2cm_front
	import i2cm_pkg::*;
(
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 push_valid,
	input  logic                 push_ready,
	output tick_t                push_data
);

	logic       cmd_valid;
	logic [2:0] func;
	logic [6:0] dev_addr;
	logic       read_not_write;
	logic [7:0] wr_data;

	assign cmd_valid      = s_tuser[0];
	assign func           = s_tuser[3:1];
	assign dev_addr       = s_tdata[6:0];
	assign read_not_write = s_tdata[7];
	assign wr_data        = s_tdata[15:8];

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	// classify the command and preload the byte the engine will shift
	always_comb begin
		push_data.kind     = CK_NONE;
		push_data.byte_val = '0;
		push_data.scl      = s_tdata[16];
		push_data.sda      = s_tdata[17];
		if (cmd_valid) begin
			unique case (func)
				FN_START: begin
					push_data.kind     = CK_START;
					push_data.byte_val = {dev_addr, read_not_write};
				end
				FN_WRITE: begin
					push_data.kind     = CK_WRITE;
					push_data.byte_val = wr_data;
				end
				FN_RD_ACK:  push_data.kind = CK_RD_ACK;
				FN_RD_NACK: push_data.kind = CK_RD_NACK;
				FN_STOP:    push_data.kind = CK_STOP;
				default:    push_data.kind = CK_NONE;
			endcase
		end
	end

endmodule

### design/i2cm_tick_fifo.sv
module i2cm_tick_fifo
	import i2cm_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  tick_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output tick_t pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	tick_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/i2cm_engine.sv
module i2cm_engine
	import i2cm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  tick_t                tick,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam logic [3:0] BITS_PER_BYTE = 4'(BYTE_BITS);

	phase_t      phase_q, ph_d;
	logic [3:0]  bc_q, bc_d, bc_inc;
	logic [7:0]  sh_q, sh_d;
	logic [7:0]  wt_q, wt_d, wt_inc;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic [1:0]  st_q, st_d;
	logic        ack_q, ack_d;
	logic [7:0]  rd_q, rd_d;
	logic        addr_q, addr_d;
	logic        done;
	logic        tmo;
	logic        busy;
	logic        pop;
	logic        out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	// take a tick whenever the output slot is free or drains this cycle
	assign pop        = tick_valid && (!out_valid_q || m_tready);
	assign tick_ready = !out_valid_q || m_tready;

	assign bc_inc = bc_q + 4'd1;
	assign wt_inc = wt_q + 8'd1;
	assign tmo    = !tick.scl && (wt_q >= cfg.stretch_timeout);

	always_comb begin
		ph_d   = phase_q;
		bc_d   = bc_q;
		sh_d   = sh_q;
		wt_d   = wt_q;
		scl_d  = scl_q;
		sda_d  = sda_q;
		st_d   = st_q;
		ack_d  = ack_q;
		rd_d   = rd_q;
		addr_d = addr_q;
		done   = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (tick.kind != CK_NONE) begin
					st_d   = ST_OK;
					bc_d   = '0;
					addr_d = 1'b0;
					unique case (tick.kind) inside
						CK_START: begin
							scl_d  = 1'b1;
							sda_d  = 1'b1;
							sh_d   = tick.byte_val;
							addr_d = 1'b1;
							ph_d   = PH_START;
						end
						CK_WRITE: begin
							sh_d = tick.byte_val;
							ph_d = PH_TX_LOW;
						end
						CK_STOP: ph_d = PH_STOP_LOW;
						CK_RD_ACK, CK_RD_NACK: begin
							ack_d = (tick.kind == CK_RD_ACK);
							sh_d  = '0;
							ph_d  = PH_RX_LOW;
						end
						default: ph_d = PH_IDLE;
					endcase
				end
			end
			PH_START: begin
				sda_d = 1'b0;
				ph_d  = PH_TX_LOW;
			end
			PH_TX_LOW: begin
				scl_d = 1'b0;
				sda_d = sh_q[7];
				ph_d  = PH_TX_RISE;
			end
			PH_TX_RISE: begin
				scl_d = 1'b1;
				wt_d  = '0;
				ph_d  = PH_TX_WAIT;
			end
			PH_TX_WAIT: begin
				if (tick.scl) begin
					if (tick.sda != sda_q) begin
						scl_d = 1'b1;
						sda_d = 1'b1;
						st_d  = ST_ARB;
						ph_d  = PH_IDLE;
						done  = 1'b1;
					end else begin
						sh_d = {sh_q[6:0], 1'b0};
						bc_d = bc_inc;
						ph_d = (bc_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
					end
				end else if (tmo) begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					st_d  = ST_TIMEOUT;
					ph_d  = PH_IDLE;
					done  = 1'b1;
				end else begin
					wt_d = wt_inc;
				end
			end
			PH_ACK_LOW: begin
				scl_d = 1'b0;
				sda_d = 1'b1;
				ph_d  = PH_ACK_RISE;
			end
			PH_ACK_RISE: begin
				scl_d = 1'b1;
				wt_d  = '0;
				ph_d  = PH_ACK_WAIT;
			end
			PH_ACK_WAIT: begin
				if (tick.scl) begin
					if (!tick.sda) begin
						scl_d = 1'b1;
						sda_d = 1'b1;
						st_d  = ST_OK;
						ph_d  = PH_IDLE;
						done  = 1'b1;
					end else if (addr_q) begin
						st_d = ST_NACK;
						ph_d = PH_STOP_LOW;
					end else begin
						scl_d = 1'b1;
						sda_d = 1'b1;
						st_d  = ST_NACK;
						ph_d  = PH_IDLE;
						done  = 1'b1;
					end
				end else if (tmo) begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					st_d  = ST_TIMEOUT;
					ph_d  = PH_IDLE;
					done  = 1'b1;
				end else begin
					wt_d = wt_inc;
				end
			end
			PH_RX_LOW: begin
				scl_d = 1'b0;
				sda_d = 1'b1;
				ph_d  = PH_RX_RISE;
			end
			PH_RX_RISE: begin
				scl_d = 1'b1;
				wt_d  = '0;
				ph_d  = PH_RX_WAIT;
			end
			PH_RX_WAIT: begin
				if (tick.scl) begin
					sh_d = {sh_q[6:0], tick.sda};
					bc_d = bc_inc;
					if (bc_inc >= BITS_PER_BYTE) begin
						rd_d = {sh_q[6:0], tick.sda};
						ph_d = PH_ANS_LOW;
					end else begin
						ph_d = PH_RX_LOW;
					end
				end else if (tmo) begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					st_d  = ST_TIMEOUT;
					ph_d  = PH_IDLE;
					done  = 1'b1;
				end else begin
					wt_d = wt_inc;
				end
			end
			PH_ANS_LOW: begin
				scl_d = 1'b0;
				sda_d = !ack_q;
				ph_d  = PH_ANS_RISE;
			end
			PH_ANS_RISE: begin
				scl_d = 1'b1;
				wt_d  = '0;
				ph_d  = PH_ANS_WAIT;
			end
			PH_ANS_WAIT: begin
				if (tick.scl) begin
					// leave SCL low after the answer clock
					scl_d = 1'b0;
					sda_d = 1'b1;
					st_d  = ST_OK;
					ph_d  = PH_IDLE;
					done  = 1'b1;
				end else if (tmo) begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					st_d  = ST_TIMEOUT;
					ph_d  = PH_IDLE;
					done  = 1'b1;
				end else begin
					wt_d = wt_inc;
				end
			end
			PH_STOP_LOW: begin
				scl_d = 1'b0;
				sda_d = 1'b0;
				ph_d  = PH_STOP_RISE;
			end
			PH_STOP_RISE: begin
				scl_d = 1'b1;
				wt_d  = '0;
				ph_d  = PH_STOP_WAIT;
			end
			PH_STOP_WAIT: begin
				if (tick.scl || tmo) begin
					if (tmo) begin
						st_d = ST_TIMEOUT;
					end
					wt_d = '0;
					ph_d = PH_STOP_SETUP;
				end else begin
					wt_d = wt_inc;
				end
			end
			PH_STOP_SETUP: begin
				if (wt_q >= cfg.stop_setup_ticks) begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					ph_d  = PH_IDLE;
					done  = 1'b1;
				end else begin
					wt_d = wt_inc;
				end
			end
			default: begin
				scl_d = 1'b1;
				sda_d = 1'b1;
				st_d  = ST_OK;
				ph_d  = PH_IDLE;
				done  = 1'b1;
			end
		endcase
	end

	assign busy = (ph_d != PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bc_q        <= '0;
			sh_q        <= '0;
			wt_q        <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			st_q        <= ST_OK;
			ack_q       <= 1'b0;
			rd_q        <= '0;
			addr_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= ph_d;
				bc_q        <= bc_d;
				sh_q        <= sh_d;
				wt_q        <= wt_d;
				scl_q       <= scl_d;
				sda_q       <= sda_d;
				st_q        <= st_d;
				ack_q       <= ack_d;
				rd_q        <= rd_d;
				addr_q      <= addr_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {2'b00, rd_d, (busy ? ST_OK : st_d), done, busy, sda_d, scl_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### design/i2cm_checker.sv
module i2cm_checker
	import i2cm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a finished command leaves the engine idle
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done reported while still busy");

	// status reads as ok while a command runs
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> (m_tdata[5:4] == ST_OK))
		else $error("nonzero status while busy");

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed under stall");

	// an idle beat drives no line low while reporting a timeout or a lost arbitration
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] && (m_tdata[5:4] == ST_TIMEOUT || m_tdata[5:4] == ST_ARB)
		|-> m_tdata[0] && m_tdata[1])
		else $error("lines not released after failure");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (.*);

### tb/sv/tb_i2c_master_byte_engine.sv
`timescale 1ns / 1ps

// I2C master byte engine: every accepted input beat is one bus tick, and every tick
// yields exactly one result beat. A local bit-level model follows the engine tick by
// tick. A bus responder picks the sampled SCL/SDA levels from that model's phase,
// so most transfers behave like a real slave would, with controlled clock
// stretching, NACKs and arbitration losses mixed in.
module tb_i2c_master_byte_engine;
	import i2cm_pkg::*;

	localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 8;    // pipeline depth plus queue, rounded up
	localparam int unsigned STALL_LIMIT  = 3000; // cycles with no beat on either side
	localparam logic [2:0]  FN_LAST      = 3'd7; // highest func code; above stop is unused

	// one input tick, as the sender builds it
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] func;
		logic [6:0] dev_addr;
		logic       rnw;
		logic [7:0] wr_data;
		logic       scl;
		logic       sda;
	} tick_beat_t;

	// one result word: line drive, busy, done, status and last byte read
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [1:0] status;
		logic [7:0] rd;
	} pin_status_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// dev_addr[6:0], read_not_write[7], wr_data[15:8], scl_in[16], sda_in[17], zero
	logic [S_TDATA_W-1:0] s_tdata;
	// cmd_valid[0], func[3:1]
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// scl_out[0], sda_out[1], busy_res[2], done_res[3], status[5:4], rd_data[13:6], zero
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_wdata;

	i2c_master_byte_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------------
	// Bit engine model: own copy of the phase machine and the two registers
	// ---------------------------------------------------------------------------
	phase_t     ph;
	logic [3:0] nbits;
	logic [7:0] shreg;
	logic [7:0] waited;
	logic       scl_drv;
	logic       sda_drv;
	logic [1:0] last_st;
	logic       ack_on;
	logic [7:0] rx_byte;
	logic       addr_byte;
	logic       done_now;
	logic [7:0] cfg_stretch;
	logic [7:0] cfg_setup;

	// results still owed by the engine, oldest first
	pin_status_t pin_status_q[$];

	// bus responder knobs
	int stretch_pct;
	int stretch_max;
	int stretch_left;
	int arb_pct;
	int nack_pct;
	bit scl_stuck;   // hold SCL low in every wait tick to force a stretch timeout

	// traffic shaping and bookkeeping
	bit src_gaps;
	bit sink_gaps;
	bit hold_req;
	int hold_left;
	int n_ticks;
	int n_work;
	int n_cmds;
	int n_done[4];
	int n_errors;
	int stall_cycles;

	pin_status_t got_res;
	pin_status_t want_res;

	// SCL sample in a wait tick: 1 seen high, 0 keep waiting, -1 stretch timeout
	function automatic int scl_sample(logic scl);
		if (scl)
			return 1;
		if (waited >= cfg_stretch)
			return -1;
		waited = waited + 8'd1;
		return 0;
	endfunction

	function automatic void finish_cmd(logic [1:0] st, logic release_lines);
		if (release_lines) begin
			scl_drv = 1'b1;
			sda_drv = 1'b1;
		end
		last_st  = st;
		ph       = PH_IDLE;
		done_now = 1'b1;
	endfunction

	// Advance the model by one tick and return the result word it owes.
	function automatic pin_status_t master_tick(tick_beat_t b);
		int          r;
		pin_status_t o;
		done_now = 1'b0;
		case (ph)
			PH_IDLE: begin
				if (b.cmd_valid && b.func <= FN_STOP) begin
					last_st   = ST_OK;
					nbits     = '0;
					addr_byte = 1'b0;
					case (b.func)
						FN_START: begin
							scl_drv   = 1'b1;
							sda_drv   = 1'b1;
							shreg     = {b.dev_addr, b.rnw};
							addr_byte = 1'b1;
							ph        = PH_START;
						end
						FN_WRITE: begin
							shreg = b.wr_data;
							ph    = PH_TX_LOW;
						end
						FN_STOP: ph = PH_STOP_LOW;
						default: begin
							ack_on = (b.func == FN_RD_ACK);
							shreg  = '0;
							ph     = PH_RX_LOW;
						end
					endcase
				end
			end
			PH_START: begin
				sda_drv = 1'b0;
				ph      = PH_TX_LOW;
			end
			PH_TX_LOW: begin
				scl_drv = 1'b0;
				sda_drv = shreg[7];
				ph      = PH_TX_RISE;
			end
			PH_TX_RISE: begin
				scl_drv = 1'b1;
				waited  = '0;
				ph      = PH_TX_WAIT;
			end
			PH_TX_WAIT: begin
				r = scl_sample(b.scl);
				if (r < 0)
					finish_cmd(ST_TIMEOUT, 1'b1);
				else if (r > 0) begin
					if (b.sda != sda_drv)
						finish_cmd(ST_ARB, 1'b1);
					else begin
						shreg = {shreg[6:0], 1'b0};
						nbits = nbits + 4'd1;
						ph    = (nbits >= BYTE_BITS) ? PH_ACK_LOW : PH_TX_LOW;
					end
				end
			end
			PH_ACK_LOW: begin
				scl_drv = 1'b0;
				sda_drv = 1'b1;
				ph      = PH_ACK_RISE;
			end
			PH_ACK_RISE: begin
				scl_drv = 1'b1;
				waited  = '0;
				ph      = PH_ACK_WAIT;
			end
			PH_ACK_WAIT: begin
				r = scl_sample(b.scl);
				if (r < 0)
					finish_cmd(ST_TIMEOUT, 1'b1);
				else if (r > 0) begin
					if (!b.sda)
						finish_cmd(ST_OK, 1'b1);
					else if (addr_byte) begin
						// address refused: close the bus with a stop of our own
						last_st = ST_NACK;
						ph      = PH_STOP_LOW;
					end else
						finish_cmd(ST_NACK, 1'b1);
				end
			end
			PH_RX_LOW: begin
				scl_drv = 1'b0;
				sda_drv = 1'b1;
				ph      = PH_RX_RISE;
			end
			PH_RX_RISE: begin
				scl_drv = 1'b1;
				waited  = '0;
				ph      = PH_RX_WAIT;
			end
			PH_RX_WAIT: begin
				r = scl_sample(b.scl);
				if (r < 0)
					finish_cmd(ST_TIMEOUT, 1'b1);
				else if (r > 0) begin
					shreg = {shreg[6:0], b.sda};
					nbits = nbits + 4'd1;
					if (nbits >= BYTE_BITS) begin
						rx_byte = shreg;
						ph      = PH_ANS_LOW;
					end else
						ph = PH_RX_LOW;
				end
			end
			PH_ANS_LOW: begin
				scl_drv = 1'b0;
				sda_drv = !ack_on;
				ph      = PH_ANS_RISE;
			end
			PH_ANS_RISE: begin
				scl_drv = 1'b1;
				waited  = '0;
				ph      = PH_ANS_WAIT;
			end
			PH_ANS_WAIT: begin
				r = scl_sample(b.scl);
				if (r < 0)
					finish_cmd(ST_TIMEOUT, 1'b1);
				else if (r > 0) begin
					// leave SCL low after the answer clock, free SDA
					scl_drv = 1'b0;
					sda_drv = 1'b1;
					finish_cmd(ST_OK, 1'b0);
				end
			end
			PH_STOP_LOW: begin
				scl_drv = 1'b0;
				sda_drv = 1'b0;
				ph      = PH_STOP_RISE;
			end
			PH_STOP_RISE: begin
				scl_drv = 1'b1;
				waited  = '0;
				ph      = PH_STOP_WAIT;
			end
			PH_STOP_WAIT: begin
				// a timeout here still finishes the stop, only the status changes
				r = scl_sample(b.scl);
				if (r != 0) begin
					if (r < 0)
						last_st = ST_TIMEOUT;
					waited = '0;
					ph     = PH_STOP_SETUP;
				end
			end
			PH_STOP_SETUP: begin
				if (waited >= cfg_setup)
					finish_cmd(last_st, 1'b1);
				else
					waited = waited + 8'd1;
			end
			default: finish_cmd(ST_OK, 1'b1);
		endcase
		o.scl    = scl_drv;
		o.sda    = sda_drv;
		o.busy   = (ph != PH_IDLE);
		o.done   = done_now;
		o.status = (ph != PH_IDLE) ? ST_OK : last_st;
		o.rd     = rx_byte;
		return o;
	endfunction

	// ---------------------------------------------------------------------------
	// Bus responder: line levels for the next tick, chosen from the model phase
	// ---------------------------------------------------------------------------
	function automatic tick_beat_t line_beat();
		tick_beat_t b;
		// command fields are noise; the engine drops them while busy
		b.cmd_valid = ($urandom_range(0, 3) == 0);
		b.func      = 3'($urandom_range(0, 7));
		b.dev_addr  = 7'($urandom);
		b.rnw       = 1'($urandom);
		b.wr_data   = 8'($urandom);
		b.scl       = 1'($urandom);
		b.sda       = 1'($urandom);
		if (ph inside {PH_TX_WAIT, PH_ACK_WAIT, PH_RX_WAIT, PH_ANS_WAIT, PH_STOP_WAIT}) begin
			if (scl_stuck)
				b.scl = 1'b0;
			else if (stretch_left > 0) begin
				b.scl = 1'b0;
				stretch_left--;
			end else if ($urandom_range(0, 99) < stretch_pct) begin
				b.scl        = 1'b0;
				stretch_left = $urandom_range(1, stretch_max) - 1;
			end else
				b.scl = 1'b1;
			if (b.scl) begin
				case (ph)
					PH_TX_WAIT:  b.sda = ($urandom_range(0, 99) < arb_pct) ? !sda_drv : sda_drv;
					PH_ACK_WAIT: b.sda = ($urandom_range(0, 99) < nack_pct);
					default:     ;  // read data and answer/stop samples stay random
				endcase
			end
		end
		return b;
	endfunction

	// idle tick: no command, or an unknown func that must be dropped
	function automatic tick_beat_t idle_beat();
		tick_beat_t b;
		b           = line_beat();
		b.cmd_valid = ($urandom_range(0, 3) == 0);
		b.func      = 3'($urandom_range(FN_STOP + 1, FN_LAST));
		return b;
	endfunction

	// ---------------------------------------------------------------------------
	// Sender: offer one tick beat, wait for the handshake, log what it owes
	// ---------------------------------------------------------------------------
	task automatic send_beat(input tick_beat_t b);
		pin_status_t r;
		while (src_gaps && $urandom_range(0, 99) < 31) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, b.sda, b.scl, b.wr_data, b.rnw, b.dev_addr};
		s_tuser  <= {b.func, b.cmd_valid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_ticks++;
		if (ph != PH_IDLE || (b.cmd_valid && b.func <= FN_STOP))
			n_work++;
		if (ph == PH_IDLE && b.cmd_valid && b.func <= FN_STOP)
			n_cmds++;
		r = master_tick(b);
		if (r.done)
			n_done[r.status]++;
		pin_status_q.push_back(r);
	endtask

	// Issue one command from idle and clock the bus until the engine is idle again.
	task automatic run_command(input logic [2:0] fn, input logic [6:0] addr, input logic rnw,
			input logic [7:0] data);
		tick_beat_t b;
		repeat ($urandom_range(0, 2))
			send_beat(idle_beat());
		b           = line_beat();
		b.cmd_valid = 1'b1;
		b.func      = fn;
		b.dev_addr  = addr;
		b.rnw       = rnw;
		b.wr_data   = data;
		send_beat(b);
		while (ph != PH_IDLE)
			send_beat(line_beat());
	endtask

	task automatic set_bus(input int stretch, input int arb, input int nack);
		stretch_pct  = stretch;
		stretch_max  = 3;
		stretch_left = 0;
		arb_pct      = arb;
		nack_pct     = nack;
		scl_stuck    = 1'b0;
	endtask

	// drop valid, let every owed result come back, then let the pipe settle
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pin_status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STRETCH)
			cfg_stretch = val;
		else
			cfg_setup = val;
	endtask

	// One transfer as software would run it: start, a few bytes, usually a stop.
	// About one in ten is a scrambled command order instead.
	task automatic random_transfer();
		logic [6:0] a;
		logic       rw;
		int         nbytes;
		a      = 7'($urandom);
		rw     = 1'($urandom);
		nbytes = $urandom_range(1, 4);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4))
				run_command(3'($urandom_range(FN_START, FN_STOP)), 7'($urandom),
					1'($urandom), 8'($urandom));
			return;
		end
		run_command(FN_START, a, rw, 8'($urandom));
		if (last_st != ST_OK)
			return;
		for (int i = 0; i < nbytes; i++) begin
			if (rw)
				run_command((i == nbytes - 1) ? FN_RD_NACK : FN_RD_ACK, a, rw, 8'($urandom));
			else
				run_command(FN_WRITE, a, rw, 8'($urandom));
			if (last_st == ST_ARB || last_st == ST_TIMEOUT)
				return;
			if (last_st != ST_OK)
				break;
		end
		// skip the stop now and then so a repeated start follows
		if ($urandom_range(0, 7) != 0)
			run_command(FN_STOP, a, rw, 8'($urandom));
	endtask

	// ---------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------

	// Clean write: highest address, all-zero, all-one and mixed bytes, then stray func codes.
	task automatic test_write_transfer();
		set_bus(0, 0, 0);
		run_command(FN_START, 7'h7F, 1'b0, 8'h00);
		run_command(FN_WRITE, 7'h00, 1'b1, 8'h00);
		run_command(FN_WRITE, 7'h00, 1'b1, 8'hFF);
		run_command(FN_WRITE, 7'h00, 1'b1, 8'h5A);
		run_command(FN_STOP, 7'h00, 1'b0, 8'h00);
		for (int f = FN_STOP + 1; f <= FN_LAST; f++)
			run_command(3'(f), 7'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// Read from address zero with ACK then NACK; the slave stretches the clock a bit.
	task automatic test_read_transfer();
		set_bus(30, 0, 0);
		run_command(FN_START, 7'h00, 1'b1, 8'h00);
		run_command(FN_RD_ACK, 7'h00, 1'b0, 8'h00);
		run_command(FN_RD_NACK, 7'h00, 1'b0, 8'hFF);
		run_command(FN_STOP, 7'h00, 1'b0, 8'h00);
	endtask

	// NACK on the address (engine closes with its own stop) and NACK on a data byte.
	task automatic test_nack_handling();
		set_bus(0, 0, 100);
		run_command(FN_START, 7'h55, 1'b0, 8'h00);
		set_bus(0, 0, 0);
		run_command(FN_START, 7'h2A, 1'b0, 8'h00);
		set_bus(0, 0, 100);
		run_command(FN_WRITE, 7'h00, 1'b0, 8'hC3);
		set_bus(0, 0, 0);
		run_command(FN_STOP, 7'h00, 1'b0, 8'h00);
	endtask

	// Lost arbitration on the first address bit, then somewhere inside a data byte.
	task automatic test_arbitration_loss();
		set_bus(0, 100, 0);
		run_command(FN_START, 7'h7F, 1'b1, 8'h00);
		set_bus(0, 0, 0);
		run_command(FN_START, 7'h11, 1'b0, 8'h00);
		set_bus(0, 15, 0);
		run_command(FN_WRITE, 7'h00, 1'b0, 8'hFF);
		set_bus(0, 0, 0);
		run_command(FN_STOP, 7'h00, 1'b0, 8'h00);
	endtask

	// Stretch timeouts at the shortest and longest limit, and one inside a stop.
	task automatic test_stretch_timeout();
		write_reg(REG_STRETCH, 8'd0);
		set_bus(50, 0, 0);
		run_command(FN_START, 7'h33, 1'b0, 8'h00);
		write_reg(REG_STRETCH, 8'd3);
		set_bus(0, 0, 0);
		scl_stuck = 1'b1;
		run_command(FN_STOP, 7'h00, 1'b0, 8'h00);
		write_reg(REG_STRETCH, 8'd255);
		scl_stuck = 1'b1;
		run_command(FN_RD_NACK, 7'h00, 1'b0, 8'h00);
		scl_stuck = 1'b0;
	endtask

	// Stop setup time at both ends of its range, then back to the reset value.
	task automatic test_stop_setup();
		set_bus(0, 0, 0);
		write_reg(REG_SETUP, 8'd0);
		run_command(FN_STOP, 7'h00, 1'b0, 8'h00);
		write_reg(REG_SETUP, 8'd255);
		run_command(FN_STOP, 7'h00, 1'b0, 8'h00);
		write_reg(REG_SETUP, SETUP_RST);
	endtask

	// Random transfers over a series of timing settings; the last setting runs
	// with no idling on either side.
	task automatic test_random_traffic();
		logic [7:0] st_vals[6] = '{8'd255, 8'd0, 8'd1, 8'd3, 8'd255, 8'd7};
		logic [7:0] su_vals[6] = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd2, 8'd5};
		logic [7:0] st;
		logic [7:0] su;
		int         goal;
		for (int p = 0; p < 6; p++) begin
			st = (p == 4) ? 8'($urandom) : st_vals[p];
			su = (p == 4) ? 8'($urandom_range(0, 15)) : su_vals[p];
			write_reg(REG_STRETCH, st);
			write_reg(REG_SETUP, su);
			set_bus((st == 8'd0) ? 3 : 15, 3, 8);
			src_gaps  = (p != 5);
			sink_gaps = (p != 5);
			goal      = n_work + 30;
			while (n_work < goal)
				random_transfer();
		end
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
	endtask

	// Receiver stops for a long stretch while the sender keeps offering ticks,
	// so the queue fills and s_tready must fall.
	task automatic test_backpressure();
		int goal;
		write_reg(REG_STRETCH, 8'd4);
		write_reg(REG_SETUP, SETUP_RST);
		set_bus(15, 3, 8);
		src_gaps = 1'b0;
		hold_req = 1'b1;
		goal     = n_work + 80;
		while (n_work < goal)
			random_transfer();
		src_gaps = 1'b1;
	endtask

	// ---------------------------------------------------------------------------
	// Receiver: random ready, plus the long hold-off counted here
	// ---------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= !sink_gaps || ($urandom_range(0, 99) >= 31);
	end

	// ---------------------------------------------------------------------------
	// Result check: compare each accepted result beat with the oldest owed word
	// ---------------------------------------------------------------------------
	function automatic void cmp_field(string name, int want, int got);
		if (want != got) begin
			if (n_errors < 50)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res.scl    = m_tdata[0];
			got_res.sda    = m_tdata[1];
			got_res.busy   = m_tdata[2];
			got_res.done   = m_tdata[3];
			got_res.status = m_tdata[5:4];
			got_res.rd     = m_tdata[13:6];
			if (pin_status_q.size() == 0) begin
				if (n_errors < 50)
					$display("%0t: result beat with nothing owed, expected none, actual %h",
						$time, m_tdata);
				n_errors++;
			end else begin
				want_res = pin_status_q.pop_front();
				cmp_field("scl_out", want_res.scl, got_res.scl);
				cmp_field("sda_out", want_res.sda, got_res.sda);
				cmp_field("busy", want_res.busy, got_res.busy);
				cmp_field("done", want_res.done, got_res.done);
				cmp_field("status", want_res.status, got_res.status);
				cmp_field("rd_data", want_res.rd, got_res.rd);
			end
		end
	end

	// Watchdog: count cycles with no beat moving on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results still owed",
					$time, stall_cycles, pin_status_q.size());
				$display("tb_i2c_master_byte_engine NOT OK");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------
	initial begin
		// hold every input at a known level and reset the block once
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_STRETCH;
		cfg_wdata = '0;
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		hold_req  = 1'b0;
		hold_left = 0;
		n_ticks   = 0;
		n_work    = 0;
		n_cmds    = 0;
		n_done    = '{0, 0, 0, 0};
		n_errors  = 0;
		stall_cycles = 0;
		set_bus(0, 0, 0);

		// model at its reset state
		ph          = PH_IDLE;
		nbits       = '0;
		shreg       = '0;
		waited      = '0;
		scl_drv     = 1'b1;
		sda_drv     = 1'b1;
		last_st     = ST_OK;
		ack_on      = 1'b0;
		rx_byte     = '0;
		addr_byte   = 1'b0;
		cfg_stretch = STRETCH_RST;
		cfg_setup   = SETUP_RST;

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_write_transfer();
		test_read_transfer();
		test_nack_handling();
		test_arbitration_loss();
		test_stretch_timeout();
		test_stop_setup();
		test_random_traffic();
		test_backpressure();
		wait_drained();

		$display("covered %0d ticks and %0d commands over shortest and longest stretch and stop timing",
			n_ticks, n_cmds);
		$display("completions: %0d ok, %0d nack, %0d arbitration lost, %0d stretch timeout",
			n_done[ST_OK], n_done[ST_NACK], n_done[ST_ARB], n_done[ST_TIMEOUT]);
		if (n_errors == 0)
			$display("tb_i2c_master_byte_engine OK");
		else
			$display("tb_i2c_master_byte_engine NOT OK");
		$finish;
	end

endmodule

### i2c_master_byte_engine.f
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_tick_fifo.sv
design/i2cm_engine.sv
design/i2c_master_byte_engine.sv
design/i2cm_checker.sv
tb/sv/tb_i2c_master_byte_engine.sv
